/* rtl/fcfd_pkg.sv */
// ----------------------------------------------------------------------------
// fcfd_pkg
// Keyword table, register indexes and result types for the framed command
// flag decoder.
// ----------------------------------------------------------------------------
package fcfd_pkg;

  localparam int KW_COUNT   = 6;
  localparam int KW_MAX_LEN = 11;
  localparam int KW_POS_W   = 4;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_START_CHAR = 1'b0,
    REG_END_CHAR   = 1'b1
  } cfg_reg_t;

  // device whose enable flag a keyword drives
  typedef enum logic [1:0] {
    DEV_ACC      = 2'd0,
    DEV_BUTTONS  = 2'd1,
    DEV_JOYSTICK = 2'd2
  } dev_t;

  // keyword text, right-justified: char i sits in byte (len - 1 - i)
  typedef logic [KW_MAX_LEN-1:0][7:0] kw_text_t;

  localparam kw_text_t KW_TEXT [KW_COUNT] = '{
    kw_text_t'("AccOff"),
    kw_text_t'("AccOn"),
    kw_text_t'("ButtonsOff"),
    kw_text_t'("ButtonsOn"),
    kw_text_t'("JoystickOff"),
    kw_text_t'("JoystickOn")
  };

  localparam logic [KW_POS_W-1:0] KW_LEN [KW_COUNT] = '{
    4'd6, 4'd5, 4'd10, 4'd9, 4'd11, 4'd10
  };

  localparam dev_t KW_DEV [KW_COUNT] = '{
    DEV_ACC, DEV_ACC, DEV_BUTTONS, DEV_BUTTONS, DEV_JOYSTICK, DEV_JOYSTICK
  };

  localparam logic KW_VAL [KW_COUNT] = '{
    1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1
  };

  // character at position pos of keyword k (valid for pos < KW_LEN[k])
  function automatic logic [7:0] kw_char(input int k, input logic [KW_POS_W-1:0] pos);
    logic [KW_POS_W-1:0] idx;
    idx = KW_LEN[k] - KW_POS_W'(1) - pos;
    return KW_TEXT[k][idx];
  endfunction

  // one result transaction
  typedef struct packed {
    logic acc_enabled;
    logic buttons_enabled;
    logic joystick_enabled;
    logic frame_closed;
    logic command_matched;
    logic frame_overflow;
  } res_t;

endpackage

/* rtl/framed_command_flag_decoder_unit.sv */
// ----------------------------------------------------------------------------
// framed_command_flag_decoder_unit
// Collects framed serial text and turns the six on/off keywords into three
// enable flags, reporting the flags after every byte.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake             payload
//  --------  ---  --------------------  -------------------------------------
//  in_       in   in_valid / in_stall   in_rx_byte[7:0]
//  out_      out  out_valid / out_stall out_acc_enabled, out_buttons_enabled,
//                                       out_joystick_enabled, out_frame_closed,
//                                       out_command_matched, out_frame_overflow
//  cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_wdata[7:0]
//
//  one byte per cycle while in_stall is low; each accepted byte yields a
//  registered result. frame state and the per-keyword prefix match bits
//  update on accept, so the incoming byte is compared against the keyword
//  table in the same cycle; only one match bit per keyword is stored.
//  a two-entry result buffer (output register plus skid) keeps input open
//  while one result waits; in_stall rises only when both entries hold data.
//  synchronous active-low reset: flags to acc off, buttons on, joystick on,
//  registers to '#' and '%', no open frame, result buffer empty.
//
module framed_command_flag_decoder_unit
  import fcfd_pkg::*;
#(
  parameter int MSG_CAPACITY = 14
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,

  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_acc_enabled,
  output logic       out_buttons_enabled,
  output logic       out_joystick_enabled,
  output logic       out_frame_closed,
  output logic       out_command_matched,
  output logic       out_frame_overflow,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_reg_t   cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam int LEN_W = $clog2(MSG_CAPACITY + 1);

  // configuration
  logic [7:0] start_char_r;
  logic [7:0] end_char_r;

  // frame state
  logic                in_frame_r, in_frame_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic                ovf_r, ovf_nxt;
  logic [KW_COUNT-1:0] match_r, match_nxt;
  logic                acc_r, acc_nxt;
  logic                btn_r, btn_nxt;
  logic                joy_r, joy_nxt;

  // result buffer
  res_t res_nxt;
  res_t out_r;
  logic out_valid_r;
  res_t skid_r;
  logic skid_valid_r;

  logic accept;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // next frame state and result for the incoming byte
  always_comb begin
    in_frame_nxt = in_frame_r;
    len_nxt      = len_r;
    ovf_nxt      = ovf_r;
    match_nxt    = match_r;
    acc_nxt      = acc_r;
    btn_nxt      = btn_r;
    joy_nxt      = joy_r;
    res_nxt      = '0;

    if (in_rx_byte == start_char_r) begin
      // start always wins, even inside a frame
      in_frame_nxt = 1'b1;
      len_nxt      = '0;
      ovf_nxt      = 1'b0;
      match_nxt    = '1;
    end else if (in_frame_r) begin
      if (in_rx_byte == end_char_r) begin
        in_frame_nxt         = 1'b0;
        res_nxt.frame_closed = 1'b1;
        if (ovf_r) begin
          res_nxt.frame_overflow = 1'b1;
        end else begin
          // keywords are distinct, so at most one hits
          for (int k = 0; k < KW_COUNT; k++) begin
            if (match_r[k] && (len_r == LEN_W'(KW_LEN[k]))) begin
              res_nxt.command_matched = 1'b1;
              case (KW_DEV[k])
                DEV_ACC:     acc_nxt = KW_VAL[k];
                DEV_BUTTONS: btn_nxt = KW_VAL[k];
                default:     joy_nxt = KW_VAL[k];
              endcase
            end
          end
        end
      end else if (in_rx_byte != 8'd0) begin
        if (len_r < LEN_W'(MSG_CAPACITY)) begin
          len_nxt = len_r + LEN_W'(1);
          // extend each keyword's prefix match by this character
          for (int k = 0; k < KW_COUNT; k++) begin
            match_nxt[k] = match_r[k] && (len_r < LEN_W'(KW_LEN[k])) &&
                           (in_rx_byte == kw_char(k, len_r[KW_POS_W-1:0]));
          end
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end

    res_nxt.acc_enabled      = acc_nxt;
    res_nxt.buttons_enabled  = btn_nxt;
    res_nxt.joystick_enabled = joy_nxt;
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_char_r <= 8'd35;
      end_char_r   <= 8'd37;
      in_frame_r   <= 1'b0;
      len_r        <= '0;
      ovf_r        <= 1'b0;
      match_r      <= '1;
      acc_r        <= 1'b0;
      btn_r        <= 1'b1;
      joy_r        <= 1'b1;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_CHAR: start_char_r <= cfg_wdata;
          REG_END_CHAR:   end_char_r   <= cfg_wdata;
          default:        ;
        endcase
      end

      if (accept) begin
        in_frame_r <= in_frame_nxt;
        len_r      <= len_nxt;
        ovf_r      <= ovf_nxt;
        match_r    <= match_nxt;
        acc_r      <= acc_nxt;
        btn_r      <= btn_nxt;
        joy_r      <= joy_nxt;
      end

      if (out_free) begin
        // skid drains first; no accept can happen while it is full
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= accept;
        end
      end else if (accept) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res_nxt;
    end else if (accept) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_acc_enabled      = out_r.acc_enabled;
  assign out_buttons_enabled  = out_r.buttons_enabled;
  assign out_joystick_enabled = out_r.joystick_enabled;
  assign out_frame_closed     = out_r.frame_closed;
  assign out_command_matched  = out_r.command_matched;
  assign out_frame_overflow   = out_r.frame_overflow;

endmodule
